[rtl/nbl_pkg.sv]
package nbl_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W   = 17;
    localparam int CRD_W     = 18;
    localparam int ABS_W     = 18;
    localparam int SPAN_W    = 19;
    localparam int DIST_W    = 20;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 6;

    localparam logic signed [CRD_W-1:0] Z_WIDEN = CRD_W'(256);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic signed [CRD_W-1:0] lo_x;
        logic signed [CRD_W-1:0] lo_y;
        logic signed [CRD_W-1:0] lo_z;
        logic signed [CRD_W-1:0] hi_x;
        logic signed [CRD_W-1:0] hi_y;
        logic signed [CRD_W-1:0] hi_z;
        logic [SPAN_W-1:0]       span;
    } t_box;

    localparam int BOX_W = $bits(t_box);

endpackage

[rtl/nbl_ram.sv]
module nbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/nbl_metric.sv]
module nbl_metric (
    input  logic                          i_clk,
    input  nbl_pkg::t_box                 i_box,
    input  nbl_pkg::t_point               i_pt,
    output logic [nbl_pkg::DIST_W-1:0]    o_metric
);
    import nbl_pkg::*;

    logic [ABS_W-1:0]  r_d [6];
    logic [SPAN_W-1:0] r_span;
    logic [DIST_W-1:0] r_metric;
    logic [DIST_W:0]   w_sum;

    function automatic logic [ABS_W-1:0] abs_diff(input logic signed [CRD_W-1:0] c,
                                                  input logic signed [COORD_W-1:0] p);
        logic signed [CRD_W:0] d;
        d = {c[CRD_W-1], c} - {{2{p[COORD_W-1]}}, p};
        if (d < 0) begin
            d = -d;
        end
        return d[ABS_W-1:0];
    endfunction

    // stage one: six distances to the faces
    always_ff @(posedge i_clk) begin
        r_d[0] <= abs_diff(i_box.lo_x, i_pt.x);
        r_d[1] <= abs_diff(i_box.hi_x, i_pt.x);
        r_d[2] <= abs_diff(i_box.lo_y, i_pt.y);
        r_d[3] <= abs_diff(i_box.hi_y, i_pt.y);
        r_d[4] <= abs_diff(i_box.lo_z, i_pt.z);
        r_d[5] <= abs_diff(i_box.hi_z, i_pt.z);
        r_span <= i_box.span;
    end

    // stage two: sum, remove the span; never negative, so drop the top bit
    assign w_sum = (DIST_W+1)'(r_d[0]) + (DIST_W+1)'(r_d[1]) + (DIST_W+1)'(r_d[2])
                 + (DIST_W+1)'(r_d[3]) + (DIST_W+1)'(r_d[4]) + (DIST_W+1)'(r_d[5])
                 - (DIST_W+1)'(r_span);

    always_ff @(posedge i_clk) begin
        r_metric <= w_sum[DIST_W-1:0];
    end

    assign o_metric = r_metric;

endmodule

[rtl/nearest_box_lookup_table.sv]
// Nearest-box table with a command-style port. Pulse i_start while o_busy is low to
// issue one word: insert a box, query a point, or clear. Every insert, query and clear
// returns one result word on o_valid for a single cycle, the cycle after the command
// finishes; the receiver cannot stall it, so capture it then. Unused op code 3 is
// dropped without a result. Clear, a query on an empty table and an insert into a full
// table never raise o_busy: their results show in the cycle after start with o_busy
// still low. An insert holds o_busy while it writes the table and shows its result in
// the cycle after that. A query scans the stored boxes through the single table read
// port and a two-stage metric unit, one box per cycle, and holds o_busy until the last
// box has left the metric unit; its result shows as o_busy goes low. Ties go to the box
// inserted first. Coordinates are fixed point with 3 fraction bits.
module nearest_box_lookup_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [nbl_pkg::OP_W-1:0]           i_op,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_ax,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_ay,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_az,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_bx,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_by,
    input  logic signed [nbl_pkg::COORD_W-1:0] i_bz,
    output logic                               o_valid,
    output logic [nbl_pkg::STATUS_W-1:0]       o_status,
    output logic [nbl_pkg::ENTRY_W-1:0]        o_entry_index,
    output logic [nbl_pkg::DIST_W-1:0]         o_distance
);
    import nbl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rd_cnt;
    t_point              r_a;
    t_point              r_b;

    logic                r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]    r_i1, r_i2, r_i3;

    logic                r_found;
    logic [DIST_W-1:0]   r_best;
    logic [IDX_W-1:0]    r_best_idx;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_out_idx;
    logic [DIST_W-1:0]   r_out_dist;

    logic                w_accept;
    logic                w_issue;
    logic [IDX_W-1:0]    w_raddr;
    t_box                w_new_box;
    t_box                w_rd_box;
    logic [BOX_W-1:0]    w_rdata;
    logic [DIST_W-1:0]   w_metric;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);
    assign w_issue  = (r_state == S_SCAN) && (r_rd_cnt < r_count);
    assign w_raddr  = r_rd_cnt[IDX_W-1:0];
    assign w_rd_box = t_box'(w_rdata);

    // order each axis, sum the spans, then widen z both ways
    always_comb begin
        logic signed [CRD_W-1:0] lo [3];
        logic signed [CRD_W-1:0] hi [3];
        logic signed [CRD_W-1:0] av [3];
        logic signed [CRD_W-1:0] bv [3];
        logic [SPAN_W-1:0]       sum;
        av[0] = CRD_W'(r_a.x);
        av[1] = CRD_W'(r_a.y);
        av[2] = CRD_W'(r_a.z);
        bv[0] = CRD_W'(r_b.x);
        bv[1] = CRD_W'(r_b.y);
        bv[2] = CRD_W'(r_b.z);
        sum = '0;
        for (int n = 0; n < 3; n++) begin
            lo[n] = (av[n] < bv[n]) ? av[n] : bv[n];
            hi[n] = (av[n] < bv[n]) ? bv[n] : av[n];
            sum   = sum + SPAN_W'($unsigned(hi[n] - lo[n]));
        end
        w_new_box.lo_x = lo[0];
        w_new_box.lo_y = lo[1];
        w_new_box.lo_z = lo[2] - Z_WIDEN;
        w_new_box.hi_x = hi[0];
        w_new_box.hi_y = hi[1];
        w_new_box.hi_z = hi[2] + Z_WIDEN;
        w_new_box.span = sum;
    end

    nbl_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_state == S_INS),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_new_box),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nbl_metric u_metric (
        .i_clk    (i_clk),
        .i_box    (w_rd_box),
        .i_pt     (r_a),
        .o_metric (w_metric)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_op)
                            OP_INSERT: begin
                                if (r_count >= CNT_W'(MAX_BOXES)) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_state <= S_INS;
                                end
                            end
                            OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                    r_found <= 1'b0;
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_valid <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_v3 && (!r_found || (w_metric < r_best))) begin
                        r_found <= 1'b1;
                    end
                    if (!w_issue && !r_v1 && !r_v2 && !r_v3) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a      <= '{x: i_ax, y: i_ay, z: i_az};
            r_b      <= '{x: i_bx, y: i_by, z: i_bz};
            r_rd_cnt <= '0;
        end else if (w_issue) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end
        r_i1 <= w_raddr;
        r_i2 <= r_i1;
        r_i3 <= r_i2;

        // strict compare keeps the earliest box on a tie
        if (r_state == S_SCAN && r_v3 && (!r_found || (w_metric < r_best))) begin
            r_best     <= w_metric;
            r_best_idx <= r_i3;
        end

        case (r_state)
            S_IDLE: begin
                r_out_idx  <= '0;
                r_out_dist <= '0;
                case (i_op)
                    OP_INSERT: r_status <= ST_FULL;
                    OP_QUERY:  r_status <= ST_EMPTY;
                    default:   r_status <= ST_CLEARED;
                endcase
            end
            S_INS: begin
                r_status   <= ST_INSERTED;
                r_out_idx  <= r_count[IDX_W-1:0];
                r_out_dist <= '0;
            end
            S_SCAN: begin
                r_status   <= ST_FOUND;
                r_out_idx  <= r_best_idx;
                r_out_dist <= r_best;
            end
            default: begin
                r_status <= ST_EMPTY;
            end
        endcase
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_index = ENTRY_W'(r_out_idx);
    assign o_distance    = r_out_dist;

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_valid)
        else $error("result strobe while a command is in progress");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count above table depth");

    a_pipe_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == S_SCAN))
        else $error("scan pipeline active outside a query");

    a_found_has_widening: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FOUND) |-> (o_distance >= DIST_W'(512)))
        else $error("query distance below the z widening");

    a_other_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |-> (o_distance == '0))
        else $error("nonzero distance on a non-query result");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import nbl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              ACCEPT_LIMIT = 7999992;
    localparam int              SETTLE_CYCLES = 80;
    localparam int              REPORT_CAP   = 150;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_point          a;
        t_point          b;
    } t_box_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry;
        logic [DIST_W-1:0]   distance;
    } t_lookup_answer;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic [OP_W-1:0]           i_op    = '0;
    logic signed [COORD_W-1:0] i_ax    = '0;
    logic signed [COORD_W-1:0] i_ay    = '0;
    logic signed [COORD_W-1:0] i_az    = '0;
    logic signed [COORD_W-1:0] i_bx    = '0;
    logic signed [COORD_W-1:0] i_by    = '0;
    logic signed [COORD_W-1:0] i_bz    = '0;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic [ENTRY_W-1:0]        o_entry_index;
    logic [DIST_W-1:0]         o_distance;

    t_box_cmd       cmd_queue[$];
    t_lookup_answer expected_answers[$];

    // shadow copy of the box table
    logic signed [CRD_W-1:0] box_lo[MAX_BOXES][3];
    logic signed [CRD_W-1:0] box_hi[MAX_BOXES][3];
    logic [SPAN_W-1:0]       box_span[MAX_BOXES];
    int                      box_total = 0;

    int mismatches = 0;
    int n_queued   = 0;
    int burst_left = 0;
    int gap_left   = 0;

    nearest_box_lookup_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_az          (i_az),
        .i_bx          (i_bx),
        .i_by          (i_by),
        .i_bz          (i_bz),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_distance    (o_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int abs_gap(int u, int v);
        return (u > v) ? u - v : v - u;
    endfunction

    task automatic apply_command(input t_box_cmd c);
        t_lookup_answer ans;
        int pa[3];
        int pb[3];
        int lo;
        int hi;
        int sum;
        int metric;
        int best;
        int best_idx;
        bit found;
        ans = '0;
        pa[0] = $signed(c.a.x);
        pa[1] = $signed(c.a.y);
        pa[2] = $signed(c.a.z);
        pb[0] = $signed(c.b.x);
        pb[1] = $signed(c.b.y);
        pb[2] = $signed(c.b.z);
        case (c.op)
            OP_INSERT: begin
                if (box_total >= MAX_BOXES) begin
                    ans.status = ST_FULL;
                end else begin
                    sum = 0;
                    for (int k = 0; k < 3; k++) begin
                        lo = (pa[k] < pb[k]) ? pa[k] : pb[k];
                        hi = (pa[k] < pb[k]) ? pb[k] : pa[k];
                        sum += hi - lo;
                        // widen z after the span sum is taken
                        if (k == 2) begin
                            lo -= Z_WIDEN;
                            hi += Z_WIDEN;
                        end
                        box_lo[box_total][k] = CRD_W'(lo);
                        box_hi[box_total][k] = CRD_W'(hi);
                    end
                    box_span[box_total] = SPAN_W'(sum);
                    ans.status = ST_INSERTED;
                    ans.entry  = ENTRY_W'(box_total);
                    box_total++;
                end
                expected_answers.push_back(ans);
            end
            OP_QUERY: begin
                best     = ACCEPT_LIMIT;
                best_idx = 0;
                found    = 1'b0;
                for (int i = 0; i < box_total; i++) begin
                    metric = 0;
                    for (int k = 0; k < 3; k++)
                        metric += abs_gap(box_lo[i][k], pa[k]) + abs_gap(box_hi[i][k], pa[k]);
                    metric -= int'(box_span[i]);
                    // strict compare keeps the earliest entry on a tie
                    if (metric < best) begin
                        best     = metric;
                        best_idx = i;
                        found    = 1'b1;
                    end
                end
                if (found) begin
                    ans.status   = ST_FOUND;
                    ans.entry    = ENTRY_W'(best_idx);
                    ans.distance = DIST_W'(best);
                end else begin
                    ans.status = ST_EMPTY;
                end
                expected_answers.push_back(ans);
            end
            OP_CLEAR: begin
                box_total  = 0;
                ans.status = ST_CLEARED;
                expected_answers.push_back(ans);
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int scale);
        int pick;
        pick = (scale == 3) ? $urandom_range(0, 2) : scale;
        case (pick)
            0: return COORD_W'($urandom);
            1: return COORD_W'(int'($urandom_range(0, 160)) - 80);
            default: begin
                case ($urandom_range(0, 5))
                    0: return COORD_W'(-65536);
                    1: return COORD_W'(65535);
                    2: return COORD_W'(0);
                    3: return COORD_W'(-1);
                    4: return COORD_W'(65534);
                    default: return COORD_W'(-65535);
                endcase
            end
        endcase
    endfunction

    function automatic t_point rand_point(int scale);
        t_point p;
        p.x = rand_coord(scale);
        p.y = rand_coord(scale);
        p.z = rand_coord(scale);
        return p;
    endfunction

    function automatic t_point mk_point(int x, int y, int z);
        t_point p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        p.z = COORD_W'(z);
        return p;
    endfunction

    task automatic push_cmd(input logic [OP_W-1:0] op, input t_point a, input t_point b);
        t_box_cmd c;
        c.op = op;
        c.a  = a;
        c.b  = b;
        cmd_queue.push_back(c);
        if (op != OP_UNUSED)
            n_queued++;
    endtask

    // driver: present the head of the command queue, hold it while busy
    always @(posedge i_clk) begin
        logic next_start;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            next_start = 1'b0;
            if (i_start) begin
                apply_command(cmd_queue.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 16);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() != 0) begin
                next_start = 1'b1;
                i_op <= cmd_queue[0].op;
                i_ax <= cmd_queue[0].a.x;
                i_ay <= cmd_queue[0].a.y;
                i_az <= cmd_queue[0].a.z;
                i_bx <= cmd_queue[0].b.x;
                i_by <= cmd_queue[0].b.y;
                i_bz <= cmd_queue[0].b.z;
            end
            i_start <= next_start;
        end
    end

    // monitor: every strobed word must match the oldest pending answer
    always @(posedge i_clk) begin
        t_lookup_answer want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches < REPORT_CAP)
                    $display("%0t: unexpected word, expected none, actual status %0d",
                             $time, o_status);
            end else begin
                want = expected_answers.pop_front();
                if (o_status !== want.status) begin
                    mismatches++;
                    if (mismatches < REPORT_CAP)
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, o_status);
                end
                if (o_entry_index !== want.entry) begin
                    mismatches++;
                    if (mismatches < REPORT_CAP)
                        $display("%0t: entry_index expected %0d, actual %0d",
                                 $time, want.entry, o_entry_index);
                end
                if (o_distance !== want.distance) begin
                    mismatches++;
                    if (mismatches < REPORT_CAP)
                        $display("%0t: distance expected %0d, actual %0d",
                                 $time, want.distance, o_distance);
                end
            end
        end
    end

    initial begin
        int scale;
        int n_ins;
        // directed words
        push_cmd(OP_QUERY, mk_point(0, 0, 0), mk_point(0, 0, 0));
        push_cmd(OP_INSERT, mk_point(-65536, -65536, -65536), mk_point(65535, 65535, 65535));
        push_cmd(OP_INSERT, mk_point(65535, 65535, 65535), mk_point(-65536, -65536, -65536));
        push_cmd(OP_QUERY, mk_point(0, 0, 0), mk_point(-1, -1, -1));
        push_cmd(OP_QUERY, mk_point(65535, 65535, 65535), mk_point(0, 0, 0));
        push_cmd(OP_QUERY, mk_point(-65536, -65536, -65536), mk_point(0, 0, 0));
        push_cmd(OP_INSERT, mk_point(100, -200, 300), mk_point(100, -200, 300));
        push_cmd(OP_INSERT, mk_point(10, -10, 10), mk_point(-10, 10, -10));
        push_cmd(OP_QUERY, mk_point(100, -200, 300), mk_point(0, 0, 0));
        push_cmd(OP_QUERY, mk_point(-65536, 65535, -65536), mk_point(0, 0, 0));
        push_cmd(OP_UNUSED, mk_point(-1, -1, -1), mk_point(-1, -1, -1));
        push_cmd(OP_CLEAR, mk_point(0, 0, 0), mk_point(0, 0, 0));
        push_cmd(OP_QUERY, mk_point(5, 5, 5), mk_point(0, 0, 0));
        push_cmd(OP_INSERT, mk_point(-8, -8, -8), mk_point(8, 8, 8));
        push_cmd(OP_INSERT, mk_point(-8, -8, -8), mk_point(8, 8, 8));
        push_cmd(OP_QUERY, mk_point(0, 0, 0), mk_point(0, 0, 0));
        push_cmd(OP_QUERY, mk_point(65535, -65536, 65535), mk_point(0, 0, 0));
        push_cmd(OP_CLEAR, mk_point(0, 0, 0), mk_point(0, 0, 0));
        push_cmd(OP_QUERY, mk_point(0, 0, 0), mk_point(0, 0, 0));

        // random sessions: usually a clear, a run of inserts with an occasional query, then queries
        while (n_queued < 1600) begin
            scale = $urandom_range(0, 3);
            if ($urandom_range(0, 3) != 0)
                push_cmd(OP_CLEAR, rand_point(0), rand_point(0));
            // some runs overfill the table
            n_ins = ($urandom_range(0, 4) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 12);
            repeat (n_ins) begin
                push_cmd(OP_INSERT, rand_point(scale), rand_point(scale));
                if ($urandom_range(0, 7) == 0)
                    push_cmd(OP_QUERY, rand_point(scale), rand_point(0));
            end
            repeat ($urandom_range(1, 8))
                push_cmd(OP_QUERY, rand_point(scale), rand_point(0));
            if ($urandom_range(0, 9) == 0)
                push_cmd(OP_UNUSED, rand_point(0), rand_point(0));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_start)
            @(posedge i_clk);
        while (expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("nearest_box_lookup_table test passed");
        else
            $display("nearest_box_lookup_table test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("nearest_box_lookup_table test failed");
        $finish;
    end

endmodule
